@@ src/tsq_pkg.sv @@
// tsq_pkg: shared types and constants for the two-stack queue
// depends on nothing; used by tsq_ctrl and two_stack_queue
package tsq_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COUNT_W = 6;

    // depth register value after reset
    localparam logic [CFG_W-1:0] CFG_DEPTH_RST = 5'd16;

    // word returned by a peek past the end of the queue (-2017)
    localparam logic signed [WORD_W-1:0] PEEK_ERR_WORD = -32'sd2017;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_EMPTY = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // where the result word comes from
    typedef enum logic [1:0] {
        DS_ZERO = 2'd0,
        DS_MEM  = 2'd1,
        DS_ERR  = 2'd2
    } t_dsel;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   item_count;
        logic                 full_flag;
        t_dsel                data_sel;
    } t_result;

endpackage

@@ src/tsq_ring_mem.sv @@
// tsq_ring_mem: ring store holding the queue words of both stacks
// one write port, one read port with registered read data; no package use
module tsq_ring_mem #(
    parameter int unsigned ENTRIES = 32,
    parameter int unsigned AW      = 5,
    parameter int unsigned DW      = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/tsq_ctrl.sv @@
// tsq_ctrl: stack levels, ring head, depth register and result register
// depends on tsq_pkg; drives the ports of tsq_ring_mem
module tsq_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 5,
    parameter int unsigned LW    = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tsq_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_accept,
    input  logic [1:0]                   i_opcode,
    input  logic [tsq_pkg::WORD_W-1:0]   i_push_value,
    input  logic [tsq_pkg::POS_W-1:0]    i_position,
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output logic [tsq_pkg::WORD_W-1:0]   o_wr_data,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    output tsq_pkg::t_result             o_res
);

    localparam int unsigned RING = 2 * DEPTH;
    localparam int unsigned PW   = AW + 1;

    logic [tsq_pkg::CFG_W-1:0] r_stack_depth;
    logic [LW-1:0]             r_in_lvl;
    logic [LW-1:0]             r_out_lvl;
    logic [AW-1:0]             r_head;
    tsq_pkg::t_result          r_res;

    logic [LW-1:0]             n_in_lvl;
    logic [LW-1:0]             n_out_lvl;
    logic [AW-1:0]             n_head;
    tsq_pkg::t_result          n_res;

    logic [LW-1:0]             eff_depth;
    logic [LW:0]               total;
    logic                      in_full;
    logic [31:0]               n_total;

    // head plus offset, folded back into the ring
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] s;
        s = (PW+1)'(base) + (PW+1)'(off);
        if (s >= (PW+1)'(RING)) begin
            s = s - (PW+1)'(RING);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        if (r_stack_depth == '0) begin
            eff_depth = LW'(1);
        end else if (32'(r_stack_depth) > DEPTH) begin
            eff_depth = LW'(DEPTH);
        end else begin
            eff_depth = LW'(r_stack_depth);
        end
    end

    assign total   = (LW+1)'(r_in_lvl) + (LW+1)'(r_out_lvl);
    assign in_full = (r_in_lvl >= eff_depth);

    always_comb begin
        n_in_lvl          = r_in_lvl;
        n_out_lvl         = r_out_lvl;
        n_head            = r_head;
        n_res.status      = tsq_pkg::ST_OK;
        n_res.data_sel    = tsq_pkg::DS_ZERO;
        o_wr_en           = 1'b0;
        o_wr_addr         = ring_add(r_head, PW'(total));
        o_wr_data         = i_push_value;
        o_rd_en           = 1'b0;
        o_rd_addr         = r_head;

        case (tsq_pkg::t_opcode'(i_opcode))
            tsq_pkg::OP_PUSH: begin
                if (in_full && (r_out_lvl != '0)) begin
                    n_res.status = tsq_pkg::ST_PUSH_FULL;
                end else begin
                    // a transfer keeps queue order in the ring, only levels move
                    if (in_full) begin
                        n_out_lvl = r_in_lvl;
                        n_in_lvl  = LW'(1);
                    end else begin
                        n_in_lvl  = r_in_lvl + LW'(1);
                    end
                    o_wr_en = i_accept;
                end
            end
            tsq_pkg::OP_POP: begin
                if (total == '0) begin
                    n_res.status = tsq_pkg::ST_POP_EMPTY;
                end else begin
                    if (r_out_lvl == '0) begin
                        n_out_lvl = r_in_lvl - LW'(1);
                        n_in_lvl  = '0;
                    end else begin
                        n_out_lvl = r_out_lvl - LW'(1);
                    end
                    n_head         = ring_add(r_head, PW'(1));
                    n_res.data_sel = tsq_pkg::DS_MEM;
                    o_rd_en        = i_accept;
                end
            end
            tsq_pkg::OP_PEEK: begin
                if (32'(i_position) < 32'(total)) begin
                    o_rd_addr      = ring_add(r_head, PW'(i_position));
                    n_res.data_sel = tsq_pkg::DS_MEM;
                    o_rd_en        = i_accept;
                end else begin
                    n_res.status   = tsq_pkg::ST_RANGE;
                    n_res.data_sel = tsq_pkg::DS_ERR;
                end
            end
            default: begin
            end
        endcase

        n_total          = 32'(n_in_lvl) + 32'(n_out_lvl);
        n_res.item_count = n_total[tsq_pkg::COUNT_W-1:0];
        n_res.full_flag  = (n_in_lvl >= eff_depth) && (n_out_lvl != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_depth <= tsq_pkg::CFG_DEPTH_RST;
            r_in_lvl      <= '0;
            r_out_lvl     <= '0;
            r_head        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stack_depth <= i_cfg_data;
            end
            if (i_accept) begin
                r_in_lvl  <= n_in_lvl;
                r_out_lvl <= n_out_lvl;
                r_head    <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ src/two_stack_queue.sv @@
// two_stack_queue: top level of the FIFO built from an input and an output stack
// depends on tsq_pkg, tsq_ctrl and tsq_ring_mem
//
// A queue of signed 32-bit words with push, pop and peek-at-position. Both
// stacks live in one ring store of 2*DEPTH words: queue position 0 (the
// oldest word) sits at the ring head, so moving the input stack onto the
// output stack only exchanges the two level counters and moves no words.
// When a word is accepted, levels and head update at the accepting clock
// edge together with the ring write or read, and the result word appears in
// the next cycle from the registered read port of the ring.
// A new word can be accepted every cycle as long as the result side keeps
// taking results; a held result stalls the input. The depth register may
// be written at any idle moment; 0 behaves as 1 and values above DEPTH as
// DEPTH. Ring entries are not cleared at reset; only written entries are
// ever read.
module two_stack_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [tsq_pkg::CFG_W-1:0]         i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic signed [tsq_pkg::WORD_W-1:0] i_push_value,
    input  logic [tsq_pkg::POS_W-1:0]         i_position,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tsq_pkg::WORD_W-1:0] o_data_out,
    output logic [1:0]                        o_status,
    output logic [tsq_pkg::COUNT_W-1:0]       o_item_count,
    output logic                              o_full_flag
);

    // ring holds both stacks, levels count up to DEPTH each
    localparam int unsigned RING = 2 * DEPTH;
    localparam int unsigned AW   = (RING > 2) ? $clog2(RING) : 1;
    localparam int unsigned LW   = (DEPTH > 1) ? $clog2(DEPTH + 1) : 1;

    logic                          accept;
    logic                          r_out_valid;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [tsq_pkg::WORD_W-1:0]    wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [tsq_pkg::WORD_W-1:0]    rd_data;
    tsq_pkg::t_result              res;

    // a held result blocks the next word unless it leaves this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tsq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .i_position   (i_position),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_res        (res)
    );

    tsq_ring_mem #(
        .ENTRIES (RING),
        .AW      (AW),
        .DW      (tsq_pkg::WORD_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // pick the result word: ring read data, peek error word, or zero
    always_comb begin
        case (res.data_sel)
            tsq_pkg::DS_MEM: o_data_out = rd_data;
            tsq_pkg::DS_ERR: o_data_out = tsq_pkg::PEEK_ERR_WORD;
            default:         o_data_out = '0;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = res.status;
    assign o_item_count = res.item_count;
    assign o_full_flag  = res.full_flag;

    // every accepted word yields a result on the next cycle
    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid
    ) else $error("accepted word produced no result");

    // an out-of-range peek carries the error word
    a_range_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tsq_pkg::ST_RANGE))
            |-> (o_data_out == tsq_pkg::PEEK_ERR_WORD)
    ) else $error("out-of-range peek without error word");

    // a refused push leaves the queue full
    a_refused_push_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tsq_pkg::ST_PUSH_FULL)) |-> o_full_flag
    ) else $error("push refused while queue not full");

    // a refused pop means the queue is empty
    a_empty_pop_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tsq_pkg::ST_POP_EMPTY))
            |-> ((o_item_count == '0) && !o_full_flag)
    ) else $error("pop refused while queue holds words");

endmodule
